### rtl/rsk_pkg.sv
// Shared types and constants for the record sort block.
// Used by the channel interfaces and the top level; depends on nothing.
package rsk_pkg;

	localparam int KEY_W  = 16;
	localparam int TAG_W  = 16;
	localparam int RANK_W = 6;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [TAG_W-1:0]        tag_t;
	typedef logic [RANK_W-1:0]       rank_t;
	// unsigned image of a signed key, same ordering
	typedef logic [KEY_W-1:0]        ord_t;

	function automatic ord_t order_of(input key_t key);
		order_of = {~key[KEY_W-1], key[KEY_W-2:0]};
	endfunction

endpackage

### rtl/rsk_in_if.sv
// Input record channel: valid/ready handshake plus one record per beat.
// Depends on rsk_pkg for the field types.
interface rsk_in_if;
	logic          valid;
	logic          ready;
	rsk_pkg::key_t sort_key;
	rsk_pkg::tag_t record_tag;
	logic          last_record;

	modport source (output valid, sort_key, record_tag, last_record, input ready);
	modport sink   (input valid, sort_key, record_tag, last_record, output ready);
endinterface

### rtl/rsk_out_if.sv
// Output channel: valid/ready handshake plus one sorted record per beat.
// Depends on rsk_pkg for the field types.
interface rsk_out_if;
	logic           valid;
	logic           ready;
	rsk_pkg::key_t  out_key;
	rsk_pkg::tag_t  out_tag;
	rsk_pkg::rank_t rank;
	logic           last_out;
	logic           overflow;

	modport source (output valid, out_key, out_tag, rank, last_out, overflow, input ready);
	modport sink   (input valid, out_key, out_tag, rank, last_out, overflow, output ready);
endinterface

### rtl/record_sort_by_key.sv
// Record sort block: collects a list of keyed records, emits them sorted.
// Depends on rsk_pkg, rsk_in_if and rsk_out_if.
//
// Usage:
//  in_ch carries one record per beat (signed key, tag, last flag). Records
//  are written to an on-chip store in arrival order, one per cycle, up to
//  MAX_RECORDS; records past that are dropped and the run is flagged with
//  overflow. A beat with last_record set ends the list and starts sorting.
//  in_ch.ready is low from then until the final sorted beat has gone out.
//  out_ch emits the n stored records in ascending signed key order, equal
//  keys in arrival order, each with its rank; last_out marks the final one.
//  Method: each result is found by one pass of a single compare unit over
//  the key store (one read per cycle), then its tag is fetched and it waits
//  on out_ch.ready; the next pass starts only after that beat has gone out.
//  A stall on out_ch.ready holds the result register and delays the next pass.
//  Reset (arst_n low) empties the list and clears the overflow flag; the
//  store contents need no clearing, since only written entries are read.
module record_sort_by_key #(
	parameter int MAX_RECORDS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	rsk_in_if.sink    in_ch,
	rsk_out_if.source out_ch
);

	localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	localparam logic [1:0] ST_COLLECT = 2'd0;
	localparam logic [1:0] ST_SCAN    = 2'd1;
	localparam logic [1:0] ST_FETCH   = 2'd2;
	localparam logic [1:0] ST_EMIT    = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] fill_q;
	logic             drop_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] rank_q;
	logic             has_prev_q;
	rsk_pkg::ord_t    prev_ord_q;
	logic [IDX_W-1:0] prev_idx_q;
	logic             best_vld_q;
	rsk_pkg::key_t    best_key_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	rsk_pkg::key_t    key_rd_s1;
	rsk_pkg::tag_t    tag_rd_q;

	rsk_pkg::key_t key_mem [MAX_RECORDS];
	rsk_pkg::tag_t tag_mem [MAX_RECORDS];

	logic             in_fire;
	logic             out_fire;
	logic             full;
	logic             rd_en;
	logic             run_last;
	logic [CNT_W-1:0] last_rank;
	rsk_pkg::ord_t    cand_ord;
	rsk_pkg::ord_t    best_ord;
	logic             after_prev;
	logic             beats_best;
	logic             take;

	// handshake
	assign in_ch.ready = (state_q == ST_COLLECT);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_fire    = out_ch.valid && out_ch.ready;
	assign full        = (fill_q == CNT_W'(MAX_RECORDS));
	assign rd_en       = (state_q == ST_SCAN) && (cnt_q < fill_q);
	assign last_rank   = fill_q - CNT_W'(1);
	assign run_last    = (CNT_W'(rank_q) == last_rank);

	// result register outputs
	assign out_ch.out_key  = best_key_q;
	assign out_ch.out_tag  = tag_rd_q;
	assign out_ch.rank     = rsk_pkg::rank_t'(rank_q);
	assign out_ch.last_out = run_last;
	assign out_ch.overflow = drop_q;

	// shared compare unit: next (key, index) after the last emitted one
	assign cand_ord   = rsk_pkg::order_of(key_rd_s1);
	assign best_ord   = rsk_pkg::order_of(best_key_q);
	assign after_prev = !has_prev_q || (cand_ord > prev_ord_q) ||
		((cand_ord == prev_ord_q) && (rd_idx_s1 > prev_idx_q));
	assign beats_best = !best_vld_q || (cand_ord < best_ord);
	assign take       = rd_vld_s1 && after_prev && beats_best;

	// record store, registered reads
	always_ff @(posedge clk) begin
		if (in_fire && !full) begin
			key_mem[fill_q[IDX_W-1:0]] <= in_ch.sort_key;
			tag_mem[fill_q[IDX_W-1:0]] <= in_ch.record_tag;
		end
		if (rd_en) begin
			key_rd_s1 <= key_mem[cnt_q[IDX_W-1:0]];
		end
		if (state_q == ST_FETCH) begin
			tag_rd_q <= tag_mem[best_idx_q];
		end
	end

	// read pipeline tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			rd_idx_s1 <= cnt_q[IDX_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_COLLECT;
			fill_q     <= '0;
			drop_q     <= 1'b0;
			cnt_q      <= '0;
			rank_q     <= '0;
			has_prev_q <= 1'b0;
			prev_ord_q <= '0;
			prev_idx_q <= '0;
			best_vld_q <= 1'b0;
			best_key_q <= '0;
			best_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (in_fire) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
						if (in_ch.last_record) begin
							state_q    <= ST_SCAN;
							cnt_q      <= '0;
							rank_q     <= '0;
							has_prev_q <= 1'b0;
							best_vld_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (take) begin
						best_vld_q <= 1'b1;
						best_key_q <= key_rd_s1;
						best_idx_q <= rd_idx_s1;
					end
					if (cnt_q == fill_q) begin
						state_q <= ST_FETCH;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_fire) begin
						if (run_last) begin
							state_q    <= ST_COLLECT;
							fill_q     <= '0;
							drop_q     <= 1'b0;
							has_prev_q <= 1'b0;
						end else begin
							state_q    <= ST_SCAN;
							cnt_q      <= '0;
							rank_q     <= rank_q + IDX_W'(1);
							has_prev_q <= 1'b1;
							prev_ord_q <= best_ord;
							prev_idx_q <= best_idx_q;
							best_vld_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_RECORDS))
		else $error("fill count beyond capacity");

	a_emit_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> best_vld_q)
		else $error("result shown without a selected record");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && has_prev_q) |->
		((best_ord > prev_ord_q) || ((best_ord == prev_ord_q) && (best_idx_q > prev_idx_q))))
		else $error("emitted record out of order");

	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !run_last) |=> (rank_q == $past(rank_q) + IDX_W'(1)))
		else $error("rank did not advance by one");

	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && run_last) |=> ((state_q == ST_COLLECT) && (fill_q == '0) && !drop_q))
		else $error("list state not cleared after final beat");

endmodule

### dv/tb_record_sort_by_key.sv
// Self-checking testbench for record_sort_by_key: directed lists, then random lists.
// Sorted beats are checked against a stable-sort predictor kept in this file.
// Depends on rsk_pkg, rsk_in_if, rsk_out_if and the record_sort_by_key RTL.
module tb_record_sort_by_key;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_RECORDS  = 64;
	localparam int RANDOM_ITEMS = 190;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 500;
	localparam int HOLD_AT_BEAT = 40;
	localparam int DRAIN_CYCLES = 80;
	localparam int DIR_ROWS     = 21;

	// key patterns for random lists
	typedef enum int {KEYS_FULL, KEYS_NARROW, KEYS_EXTREME} key_mode_t;

	typedef struct packed {
		rsk_pkg::key_t  key;
		rsk_pkg::tag_t  tag;
		rsk_pkg::rank_t rank;
		logic           last;
		logic           ovf;
	} sorted_beat_t;

	typedef struct packed {
		rsk_pkg::key_t key;
		rsk_pkg::tag_t tag;
		logic          last;
		logic          typed;
		sorted_beat_t  exp;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rsk_in_if  in_ch();
	rsk_out_if out_ch();

	record_sort_by_key #(.MAX_RECORDS(MAX_RECORDS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state: records held for the current list
	rsk_pkg::key_t held_keys[MAX_RECORDS];
	rsk_pkg::tag_t held_tags[MAX_RECORDS];
	int unsigned   held_count;
	bit            held_dropped;

	sorted_beat_t pending_sorted[$];

	int unsigned mismatches;
	int unsigned beats_checked;
	int unsigned records_sent;
	int unsigned lists_sent;
	int unsigned overflow_runs;
	int unsigned stall_cycles;

	// directed lists; single-record lists carry their result typed in
	dir_row_t dir_rows[DIR_ROWS] = '{
		// lone records at the key and tag extremes and at zero
		'{-32768, 16'h0000, 1'b1, 1'b1, '{-32768, 16'h0000, 6'd0, 1'b1, 1'b0}},
		'{ 32767, 16'hFFFF, 1'b1, 1'b1, '{ 32767, 16'hFFFF, 6'd0, 1'b1, 1'b0}},
		'{     0, 16'h5A5A, 1'b1, 1'b1, '{     0, 16'h5A5A, 6'd0, 1'b1, 1'b0}},
		// descending keys, full reversal
		'{ 32767, 16'h0001, 1'b0, 1'b0, '0},
		'{   100, 16'h0002, 1'b0, 1'b0, '0},
		'{     0, 16'h0003, 1'b0, 1'b0, '0},
		'{    -1, 16'h0004, 1'b0, 1'b0, '0},
		'{-32768, 16'h0005, 1'b1, 1'b0, '0},
		// equal keys must keep arrival order
		'{     7, 16'h00A0, 1'b0, 1'b0, '0},
		'{     7, 16'h00A1, 1'b0, 1'b0, '0},
		'{    -3, 16'h00A2, 1'b0, 1'b0, '0},
		'{     7, 16'h00A3, 1'b1, 1'b0, '0},
		// already sorted
		'{    -5, 16'h1111, 1'b0, 1'b0, '0},
		'{    -4, 16'h2222, 1'b0, 1'b0, '0},
		'{    -3, 16'h4444, 1'b0, 1'b0, '0},
		'{     2, 16'h8888, 1'b0, 1'b0, '0},
		'{     9, 16'hFFFE, 1'b1, 1'b0, '0},
		// repeated extremes, signed compare across the sign bit
		'{ 32767, 16'hC000, 1'b0, 1'b0, '0},
		'{-32768, 16'hC001, 1'b0, 1'b0, '0},
		'{ 32767, 16'hC002, 1'b0, 1'b0, '0},
		'{-32768, 16'hC003, 1'b1, 1'b0, '0}
	};

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// accept one record into the predictor; on the last one, queue the sorted run
	task automatic take_record(input rsk_pkg::key_t key, input rsk_pkg::tag_t tag,
			input logic last);
		int unsigned  order_idx[MAX_RECORDS];
		int unsigned  i;
		int unsigned  j;
		sorted_beat_t beat;
		if (held_count < MAX_RECORDS) begin
			held_keys[held_count] = key;
			held_tags[held_count] = tag;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (last) begin
			// stable insertion sort of store indices, signed keys
			for (i = 0; i < held_count; i++) begin
				j = i;
				while (j > 0 && held_keys[order_idx[j-1]] > held_keys[i]) begin
					order_idx[j] = order_idx[j-1];
					j--;
				end
				order_idx[j] = i;
			end
			for (i = 0; i < held_count; i++) begin
				beat.key  = held_keys[order_idx[i]];
				beat.tag  = held_tags[order_idx[i]];
				beat.rank = rsk_pkg::rank_t'(i);
				beat.last = (i + 1 == held_count);
				beat.ovf  = held_dropped;
				pending_sorted.push_back(beat);
			end
			if (held_dropped)
				overflow_runs++;
			lists_sent++;
			held_count   = 0;
			held_dropped = 1'b0;
		end
	endtask

	// offer one record beat and wait for the handshake
	task automatic send_record(input rsk_pkg::key_t key, input rsk_pkg::tag_t tag,
			input logic last, input bit steady);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.sort_key    <= key;
		in_ch.record_tag  <= tag;
		in_ch.last_record <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		take_record(key, tag, last);
		records_sent++;
	endtask

	// one random list of len records
	task automatic send_list(input int unsigned len, input key_mode_t mode, input bit steady);
		int unsigned   k;
		rsk_pkg::key_t key;
		for (k = 0; k < len; k++) begin
			case (mode)
				KEYS_NARROW: begin
					key = rsk_pkg::key_t'($signed($urandom_range(0, 6)) - 3);
				end
				KEYS_EXTREME: begin
					case ($urandom_range(0, 4))
						0: key = -32768;
						1: key = -1;
						2: key = 0;
						3: key = 1;
						default: key = 32767;
					endcase
				end
				default: begin
					key = rsk_pkg::key_t'($urandom_range(0, 65535));
				end
			endcase
			send_record(key, rsk_pkg::tag_t'($urandom_range(0, 65535)), k == len - 1, steady);
		end
	endtask

	// output checker and stall watchdog
	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (out_ch.valid && out_ch.ready) begin
				beats_checked++;
				if (pending_sorted.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected sorted beat: key %0d tag %h rank %0d",
							out_ch.out_key, out_ch.out_tag, out_ch.rank);
				end else begin
					want = pending_sorted.pop_front();
					if (out_ch.out_key !== want.key || out_ch.out_tag !== want.tag ||
							out_ch.rank !== want.rank || out_ch.last_out !== want.last ||
							out_ch.overflow !== want.ovf) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("beat mismatch: exp key %0d tag %h rank %0d last %b ovf %b",
								want.key, want.tag, want.rank, want.last, want.ovf);
							$display(" / got key %0d tag %h rank %0d last %b ovf %b",
								out_ch.out_key, out_ch.out_tag, out_ch.rank,
								out_ch.last_out, out_ch.overflow);
						end
					end
				end
			end
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// receiver: random ready gaps, one long hold-off to back the block up
	initial begin
		bit          held_off;
		int unsigned gap;
		held_off     = 1'b0;
		out_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (!held_off && beats_checked >= HOLD_AT_BEAT) begin
				held_off = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap != 0) begin
					out_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// main sequence: reset, directed table, random lists, drain
	initial begin
		int unsigned row;
		int unsigned list_no;
		int unsigned rand_records;
		int unsigned len;
		key_mode_t   mode;
		mismatches        = 0;
		beats_checked     = 0;
		records_sent      = 0;
		lists_sent        = 0;
		overflow_runs     = 0;
		stall_cycles      = 0;
		held_count        = 0;
		held_dropped      = 1'b0;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.sort_key    = '0;
		in_ch.record_tag  = '0;
		in_ch.last_record = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lists
		for (row = 0; row < DIR_ROWS; row++) begin
			send_record(dir_rows[row].key, dir_rows[row].tag, dir_rows[row].last, 1'b0);
			if (dir_rows[row].typed)
				pending_sorted[$] = dir_rows[row].exp;
		end

		// random lists: mostly short, one exactly full, one past capacity
		list_no      = 0;
		rand_records = 0;
		while (rand_records < RANDOM_ITEMS) begin
			case (list_no)
				3: len = MAX_RECORDS;
				7: len = MAX_RECORDS + 2;
				default: len = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 24)
					: $urandom_range(1, 10);
			endcase
			case ($urandom_range(0, 3))
				0: mode = KEYS_NARROW;
				1: mode = KEYS_EXTREME;
				default: mode = KEYS_FULL;
			endcase
			send_list(len, mode, $urandom_range(0, 3) == 0);
			rand_records += len;
			list_no++;
		end
		in_ch.valid <= 1'b0;

		// drain
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d lists, %0d records, %0d runs past capacity",
			lists_sent, records_sent, overflow_runs);
		$display("checked %0d sorted beats, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0 && pending_sorted.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (pending_sorted.size() != 0)
				$display("%0d sorted beats never arrived", pending_sorted.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
